>>> design/spci_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spci_pkg
// Shared types for the sphere pair collision impulse pipeline.
// ----------------------------------------------------------------------------
package spci_pkg;

    // Control flags that travel down the pipeline with each item
    typedef struct packed {
        logic valid;
        logic overlap;
        logic applied;
        logic go;
    } spci_flags_t;

endpackage
`default_nettype wire

>>> design/spci_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spci_if
// Valid/ready channels: sphere pair in, impulse out, restitution write.
// ----------------------------------------------------------------------------
interface spci_pair_if #(parameter int COMP_WIDTH = 16);
    logic                    valid;
    logic                    ready;
    logic [3*COMP_WIDTH-1:0] pos_a;
    logic [3*COMP_WIDTH-1:0] pos_b;
    logic [3*COMP_WIDTH-1:0] vel_a;
    logic [3*COMP_WIDTH-1:0] vel_b;
    logic [COMP_WIDTH-1:0]   mass_a;
    logic [COMP_WIDTH-1:0]   mass_b;
    logic [COMP_WIDTH-1:0]   radius_a;
    logic [COMP_WIDTH-1:0]   radius_b;

    modport source (output valid, pos_a, pos_b, vel_a, vel_b, mass_a, mass_b,
                    radius_a, radius_b, input ready);
    modport sink (input valid, pos_a, pos_b, vel_a, vel_b, mass_a, mass_b,
                  radius_a, radius_b, output ready);
endinterface

interface spci_impulse_if #(parameter int COMP_WIDTH = 16);
    logic                    valid;
    logic                    ready;
    logic [3*COMP_WIDTH-1:0] impulse_on_a;
    logic                    overlapping;
    logic                    impulse_applied;
    logic                    saturated;

    modport source (output valid, impulse_on_a, overlapping, impulse_applied,
                    saturated, input ready);
    modport sink (input valid, impulse_on_a, overlapping, impulse_applied,
                  saturated, output ready);
endinterface

interface spci_cfg_if #(parameter int FRAC_BITS = 8);
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   restitution;

    modport source (output valid, restitution, input ready);
    modport sink (input valid, restitution, output ready);
endinterface
`default_nettype wire

>>> design/spci_geom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spci_geom
// Stages 1-3: differences, squares and dot terms, sums and overlap test.
// ----------------------------------------------------------------------------
module spci_geom #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 en,
    input  wire logic                                 in_valid,
    input  wire logic [3*COMP_WIDTH-1:0]              pos_a,
    input  wire logic [3*COMP_WIDTH-1:0]              pos_b,
    input  wire logic [3*COMP_WIDTH-1:0]              vel_a,
    input  wire logic [3*COMP_WIDTH-1:0]              vel_b,
    input  wire logic [COMP_WIDTH-1:0]                mass_a,
    input  wire logic [COMP_WIDTH-1:0]                mass_b,
    input  wire logic [COMP_WIDTH-1:0]                radius_a,
    input  wire logic [COMP_WIDTH-1:0]                radius_b,
    input  wire logic [FRAC_BITS:0]                   restitution,
    output spci_pkg::spci_flags_t                     flags,
    output logic [2*COMP_WIDTH+3:0]                   d2,
    output logic [2*COMP_WIDTH+3:0]                   dmag,
    output logic [FRAC_BITS:0]                        e,
    output logic [2*COMP_WIDTH-1:0]                   mm,
    output logic [COMP_WIDTH:0]                       ms,
    output logic [2:0][COMP_WIDTH:0]                  rmag,
    output logic [2:0]                                neg
);
    import spci_pkg::*;

    localparam int W   = COMP_WIDTH;
    localparam int RW  = W + 1;
    localparam int R2W = 2 * RW;
    localparam int SW2 = 2 * W + 4;
    localparam int EW  = FRAC_BITS + 1;
    localparam logic [EW-1:0] E_ONE = EW'(1) << FRAC_BITS;

    // stage 1
    logic                        s1_valid_reg;
    logic [2:0][RW-1:0]          r_reg, r_next;
    logic [2:0][RW-1:0]          dv_reg, dv_next;
    logic [W:0]                  sumr_reg;
    logic [W-1:0]                ma_reg, mb_reg;
    logic [EW-1:0]               e1_reg;

    // stage 2
    logic                        s2_valid_reg;
    logic [2:0][2*RW-1:0]        sq_reg, sq_next;
    logic [2:0][2*RW-1:0]        pr_reg, pr_next;
    logic [2*W+1:0]              sr2_reg;
    logic [2*W-1:0]              mm2_reg;
    logic [W:0]                  ms2_reg;
    logic [EW-1:0]               e2_reg;
    logic [2:0][RW-1:0]          rmag2_reg, rmag2_next;
    logic [2:0]                  neg2_reg, neg2_next;

    // stage 3
    spci_flags_t                 flags_reg, flags_next;
    logic [SW2-1:0]              d2_reg, d2_next;
    logic [SW2-1:0]              dmag_reg, dmag_next;
    logic signed [SW2-1:0]       dot_next;
    logic [EW-1:0]               e3_reg;
    logic [2*W-1:0]              mm3_reg;
    logic [W:0]                  ms3_reg;
    logic [2:0][RW-1:0]          rmag3_reg;
    logic [2:0]                  neg3_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            r_next[i]  = RW'($signed({pos_b[i*W+W-1], pos_b[i*W +: W]})
                       - $signed({pos_a[i*W+W-1], pos_a[i*W +: W]}));
            dv_next[i] = RW'($signed({vel_b[i*W+W-1], vel_b[i*W +: W]})
                       - $signed({vel_a[i*W+W-1], vel_a[i*W +: W]}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            flags_reg    <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            flags_reg    <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= r_next;
            dv_reg   <= dv_next;
            sumr_reg <= {1'b0, radius_a} + {1'b0, radius_b};
            ma_reg   <= mass_a;
            mb_reg   <= mass_b;
            e1_reg   <= (restitution > E_ONE) ? E_ONE : restitution;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i]    = R2W'($signed(r_reg[i]) * $signed(r_reg[i]));
            pr_next[i]    = R2W'($signed(r_reg[i]) * $signed(dv_reg[i]));
            rmag2_next[i] = r_reg[i][RW-1] ? RW'(-r_reg[i]) : r_reg[i];
            neg2_next[i]  = !r_reg[i][RW-1] && (r_reg[i] != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg    <= sq_next;
            pr_reg    <= pr_next;
            sr2_reg   <= sumr_reg * sumr_reg;
            mm2_reg   <= ma_reg * mb_reg;
            ms2_reg   <= {1'b0, ma_reg} + {1'b0, mb_reg};
            e2_reg    <= e1_reg;
            rmag2_reg <= rmag2_next;
            neg2_reg  <= neg2_next;
        end
    end

    always_comb
    begin
        d2_next  = SW2'(sq_reg[0]) + SW2'(sq_reg[1]) + SW2'(sq_reg[2]);
        dot_next = SW2'($signed(pr_reg[0])) + SW2'($signed(pr_reg[1]))
                 + SW2'($signed(pr_reg[2]));
        dmag_next = dot_next[SW2-1] ? SW2'(-dot_next) : SW2'(dot_next);
        flags_next.valid   = s2_valid_reg;
        flags_next.overlap = d2_next < SW2'(sr2_reg);
        flags_next.applied = flags_next.overlap && (d2_next != '0) && dot_next[SW2-1];
        flags_next.go      = flags_next.applied && (ms2_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d2_reg    <= d2_next;
            dmag_reg  <= dmag_next;
            e3_reg    <= e2_reg;
            mm3_reg   <= mm2_reg;
            ms3_reg   <= ms2_reg;
            rmag3_reg <= rmag2_reg;
            neg3_reg  <= neg2_reg;
        end
    end

    assign flags = flags_reg;
    assign d2    = d2_reg;
    assign dmag  = dmag_reg;
    assign e     = e3_reg;
    assign mm    = mm3_reg;
    assign ms    = ms3_reg;
    assign rmag  = rmag3_reg;
    assign neg   = neg3_reg;

endmodule
`default_nettype wire

>>> design/spci_prod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spci_prod
// Stages 4-6: numerator and denominator products, wide product split in two.
// ----------------------------------------------------------------------------
module spci_prod #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  spci_pkg::spci_flags_t                      flags_in,
    input  wire logic [2*COMP_WIDTH+3:0]               d2,
    input  wire logic [2*COMP_WIDTH+3:0]               dmag,
    input  wire logic [FRAC_BITS:0]                    e,
    input  wire logic [2*COMP_WIDTH-1:0]               mm,
    input  wire logic [COMP_WIDTH:0]                   ms,
    input  wire logic [2:0][COMP_WIDTH:0]              rmag,
    input  wire logic [2:0]                            neg_in,
    output spci_pkg::spci_flags_t                      flags,
    output logic [2:0][(2*COMP_WIDTH+4)+(FRAC_BITS+2)+(3*COMP_WIDTH+1)-1:0] num,
    output logic [(2*COMP_WIDTH+4)+COMP_WIDTH:0]       den,
    output logic [2:0]                                 neg
);
    import spci_pkg::*;

    localparam int W    = COMP_WIDTH;
    localparam int RW   = W + 1;
    localparam int SW2  = 2 * W + 4;
    localparam int SAW  = FRAC_BITS + 2;
    localparam int AW   = SW2 + SAW;
    localparam int RMW  = RW + 2 * W;
    localparam int NUMW = AW + RMW;
    localparam int DENW = SW2 + W + 1;
    localparam int AL   = AW / 2;
    localparam int AH   = AW - AL;

    spci_flags_t              f4_reg, f5_reg, f6_reg;
    logic [AW-1:0]            a_reg;
    logic [DENW-1:0]          den4_reg, den5_reg, den6_reg;
    logic [2:0][RMW-1:0]      rm_reg, rm_next;
    logic [2:0]               neg4_reg, neg5_reg, neg6_reg;
    logic [2:0][AL+RMW-1:0]   pl_reg, pl_next;
    logic [2:0][AH+RMW-1:0]   ph_reg, ph_next;
    logic [2:0][NUMW-1:0]     num_reg, num_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f4_reg <= '0;
            f5_reg <= '0;
            f6_reg <= '0;
        end
        else if (en)
        begin
            f4_reg <= flags_in;
            f5_reg <= f4_reg;
            f6_reg <= f5_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rm_next[i] = RMW'(rmag[i]) * RMW'(mm);
            pl_next[i] = (AL+RMW)'(a_reg[AL-1:0]) * (AL+RMW)'(rm_reg[i]);
            ph_next[i] = (AH+RMW)'(a_reg[AW-1:AL]) * (AH+RMW)'(rm_reg[i]);
            num_next[i] = NUMW'(pl_reg[i]) + (NUMW'(ph_reg[i]) << AL);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= AW'(dmag) * AW'((SAW'(1) << FRAC_BITS) + SAW'(e));
            den4_reg <= DENW'(d2) * DENW'(ms);
            rm_reg   <= rm_next;
            neg4_reg <= neg_in;
            pl_reg   <= pl_next;
            ph_reg   <= ph_next;
            den5_reg <= den4_reg;
            neg5_reg <= neg4_reg;
            num_reg  <= num_next;
            den6_reg <= den5_reg;
            neg6_reg <= neg5_reg;
        end
    end

    assign flags = f6_reg;
    assign num   = num_reg;
    assign den   = den6_reg;
    assign neg   = neg6_reg;

endmodule
`default_nettype wire

>>> design/spci_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spci_div
// Restoring divider, one quotient bit per stage: overflow check stage,
// then COMP_WIDTH bit stages for all three components in parallel.
// ----------------------------------------------------------------------------
module spci_div #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  en,
    input  spci_pkg::spci_flags_t                      flags_in,
    input  wire logic [2:0][(2*COMP_WIDTH+4)+(FRAC_BITS+2)+(3*COMP_WIDTH+1)-1:0] num,
    input  wire logic [(2*COMP_WIDTH+4)+COMP_WIDTH:0]  den,
    input  wire logic [2:0]                            neg_in,
    output spci_pkg::spci_flags_t                      flags,
    output logic [2:0][COMP_WIDTH-1:0]                 quo,
    output logic [2:0]                                 ovf,
    output logic [2:0]                                 neg
);
    import spci_pkg::*;

    localparam int W    = COMP_WIDTH;
    localparam int SW2  = 2 * W + 4;
    localparam int NUMW = SW2 + (FRAC_BITS + 2) + (3 * W + 1);
    localparam int DENW = SW2 + W + 1;
    localparam int DSW  = DENW + 2 * FRAC_BITS;
    localparam int CW   = ((NUMW > DSW + W) ? NUMW : DSW + W) + 1;
    localparam int NS   = W + 1;

    spci_flags_t           fl_w  [0:NS];
    logic [2:0][CW-1:0]    rem_w [0:NS];
    logic [2:0][W-1:0]     q_w   [0:NS];
    logic [2:0]            ovf_w [0:NS];
    logic [2:0]            neg_w [0:NS];
    logic [DSW-1:0]        ds_w  [0:NS];

    assign fl_w[0]  = flags_in;
    assign q_w[0]   = '0;
    assign ovf_w[0] = '0;
    assign neg_w[0] = neg_in;
    // divide by den * 2^(2F) so the quotient is already rescaled
    assign ds_w[0]  = DSW'(den) << (2 * FRAC_BITS);
    assign rem_w[0] = {CW'(num[2]), CW'(num[1]), CW'(num[0])};

    for (genvar s = 1; s <= NS; s++)
    begin : g_stage
        spci_flags_t         fl_reg;
        logic [2:0][CW-1:0]  rem_reg, rem_next;
        logic [2:0][W-1:0]   q_reg, q_next;
        logic [2:0]          ovf_reg, ovf_next;
        logic [2:0]          neg_reg;
        logic [DSW-1:0]      ds_reg;
        logic [CW-1:0]       thr;

        // stage 1 compares against 2^W * divisor, later stages one bit each
        assign thr = CW'(ds_w[s-1]) << (NS - s);

        always_comb
        begin
            rem_next = rem_w[s-1];
            q_next   = q_w[s-1];
            ovf_next = ovf_w[s-1];
            for (int i = 0; i < 3; i++)
            begin
                if (s == 1)
                begin
                    ovf_next[i] = rem_w[s-1][i] >= thr;
                end
                else if (rem_w[s-1][i] >= thr)
                begin
                    rem_next[i] = rem_w[s-1][i] - thr;
                    q_next[i][(s == 1) ? 0 : NS - s] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fl_reg <= '0;
            end
            else if (en)
            begin
                fl_reg <= fl_w[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                ovf_reg <= ovf_next;
                neg_reg <= neg_w[s-1];
                ds_reg  <= ds_w[s-1];
            end
        end

        assign fl_w[s]  = fl_reg;
        assign rem_w[s] = rem_reg;
        assign q_w[s]   = q_reg;
        assign ovf_w[s] = ovf_reg;
        assign neg_w[s] = neg_reg;
        assign ds_w[s]  = ds_reg;
    end

    assign flags = fl_w[NS];
    assign quo   = q_w[NS];
    assign ovf   = ovf_w[NS];
    assign neg   = neg_w[NS];

endmodule
`default_nettype wire

>>> design/sphere_pair_collision_impulse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sphere_pair_collision_impulse
// Elastic collision impulse for a pair of spheres, fixed point, pipelined.
// ----------------------------------------------------------------------------
// Channels: pair (valid/ready) carries two spheres; result (valid/ready)
// returns one item per pair: impulse on sphere a (b takes the negation),
// overlap, applied and saturation flags. cfg writes the restitution
// coefficient; it is always ready. The user must write it only while the
// block idles; the block itself does not enforce this. Throughput: one
// pair per cycle unless the receiver stalls. A pair passes through 3
// geometry stages, 3 product stages, COMP_WIDTH + 1 divider stages (an
// overflow check, then one quotient bit each) and the output register.
// A stalled receiver holds the whole pipeline; the output register keeps
// its item and pair.ready drops only while that item waits and the
// receiver is not ready. Nothing is lost or repeated.
// Reset clears all valid bits and sets restitution to 1.0.
// ----------------------------------------------------------------------------
module sphere_pair_collision_impulse #(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    spci_pair_if.sink        pair,
    spci_impulse_if.source   result,
    spci_cfg_if.sink         cfg
);
    import spci_pkg::*;

    localparam int W    = COMP_WIDTH;
    localparam int EW   = FRAC_BITS + 1;
    localparam int SW2  = 2 * W + 4;
    localparam int NUMW = SW2 + (FRAC_BITS + 2) + (3 * W + 1);
    localparam int DENW = SW2 + W + 1;
    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

    logic                    en;
    logic [EW-1:0]           restitution_reg;

    spci_flags_t             g_flags, p_flags, d_flags;
    logic [SW2-1:0]          g_d2, g_dmag;
    logic [EW-1:0]           g_e;
    logic [2*W-1:0]          g_mm;
    logic [W:0]              g_ms;
    logic [2:0][W:0]         g_rmag;
    logic [2:0]              g_neg, p_neg, d_neg, d_ovf;
    logic [2:0][NUMW-1:0]    p_num;
    logic [DENW-1:0]         p_den;
    logic [2:0][W-1:0]       d_quo;

    logic                    out_valid_reg;
    logic [3*W-1:0]          imp_reg, imp_next;
    logic                    ovl_reg, app_reg, sat_reg, sat_next;

    // advance everything unless the output item is held
    assign en          = !out_valid_reg || result.ready;
    assign pair.ready  = en;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restitution_reg <= EW'(1) << FRAC_BITS;
        end
        else if (cfg.valid)
        begin
            restitution_reg <= cfg.restitution;
        end
    end

    spci_geom #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_geom (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (pair.valid),
        .pos_a       (pair.pos_a),
        .pos_b       (pair.pos_b),
        .vel_a       (pair.vel_a),
        .vel_b       (pair.vel_b),
        .mass_a      (pair.mass_a),
        .mass_b      (pair.mass_b),
        .radius_a    (pair.radius_a),
        .radius_b    (pair.radius_b),
        .restitution (restitution_reg),
        .flags       (g_flags),
        .d2          (g_d2),
        .dmag        (g_dmag),
        .e           (g_e),
        .mm          (g_mm),
        .ms          (g_ms),
        .rmag        (g_rmag),
        .neg         (g_neg)
    );

    spci_prod #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .flags_in (g_flags),
        .d2       (g_d2),
        .dmag     (g_dmag),
        .e        (g_e),
        .mm       (g_mm),
        .ms       (g_ms),
        .rmag     (g_rmag),
        .neg_in   (g_neg),
        .flags    (p_flags),
        .num      (p_num),
        .den      (p_den),
        .neg      (p_neg)
    );

    spci_div #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .flags_in (p_flags),
        .num      (p_num),
        .den      (p_den),
        .neg_in   (p_neg),
        .flags    (d_flags),
        .quo      (d_quo),
        .ovf      (d_ovf),
        .neg      (d_neg)
    );

    // clip each magnitude and apply the sign
    always_comb
    begin
        logic [W-1:0] lim;
        logic [W-1:0] mag;
        imp_next = '0;
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            lim = d_neg[i] ? LIM_NEG : LIM_POS;
            if (d_ovf[i] || (d_quo[i] > lim))
            begin
                mag = lim;
                if (d_flags.go)
                begin
                    sat_next = 1'b1;
                end
            end
            else
            begin
                mag = d_quo[i];
            end
            if (d_flags.go)
            begin
                imp_next[i*W +: W] = d_neg[i] ? W'(-mag) : mag;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d_flags.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            imp_reg <= imp_next;
            ovl_reg <= d_flags.overlap;
            app_reg <= d_flags.applied;
            sat_reg <= sat_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.impulse_on_a    = imp_reg;
    assign result.overlapping     = ovl_reg;
    assign result.impulse_applied = app_reg;
    assign result.saturated       = sat_reg;

endmodule
`default_nettype wire
